// ===== hdl/svcb_dnr_param_parser_assert.svh =====
// Assertion macros for the DNR SvcParams parser.
// Included by the top level; no other dependencies.
`ifndef SVCB_DNR_PARAM_PARSER_ASSERT_SVH
`define SVCB_DNR_PARAM_PARSER_ASSERT_SVH

`ifndef SYNTH
`define DNR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DNR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DNR_ASSERT(lbl, clk, rst_n, prop, msg)
`define DNR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hdl/dnr_pkg.sv =====
// Shared types and constants for the DNR SvcParams parser.
// Used by dnr_parse_core and svcb_dnr_param_parser; no dependencies.
package dnr_pkg;

    localparam int DEF_OFFSET_WIDTH = 16;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOUSE = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // SvcParam keys
    localparam logic [15:0] KEY_MANDATORY = 16'd0;
    localparam logic [15:0] KEY_ALPN      = 16'd1;
    localparam logic [15:0] KEY_PORT      = 16'd3;
    localparam logic [15:0] KEY_IPV4HINT  = 16'd4;
    localparam logic [15:0] KEY_IPV6HINT  = 16'd6;
    localparam logic [15:0] KEY_DOHPATH   = 16'd7;

    // ALPN ids, first character in the low byte
    localparam logic [23:0] ID_DOT = 24'h746F64;
    localparam logic [23:0] ID_H2  = 24'h003268;
    localparam logic [23:0] ID_H3  = 24'h003368;
    localparam logic [23:0] ID_DOQ = 24'h716F64;

    typedef struct packed {
        logic [1:0]  status;
        logic        use_dot;
        logic        use_http2;
        logic        use_http3;
        logic        use_quic;
        logic [15:0] service_port;
        logic        path_present;
        logic [15:0] path_offset;
        logic [15:0] path_length;
    } t_result;

endpackage

// ===== hdl/svcb_dnr_param_parser.sv =====
// Top level of the DNR SvcParams parser: input register, parser core, result register.
// Depends on dnr_pkg, dnr_parse_core and svcb_dnr_param_parser_assert.svh.
//
// Usage: the bytes of one SvcParams block arrive on the input channel, one beat per
// byte (i_data_byte), with i_final_byte high on the last beat. A beat is taken when
// i_valid and o_ready are both high. Exactly one result beat follows each final
// beat on the output channel (o_valid / i_ready), carrying the status, the
// transport flags, the port and the dohpath position and length.
// A final beat goes through the input register and then the result register to o_valid.
// Throughput: one byte per cycle while no final beat waits on a held result; the parser
// core updates its registers once per beat through a single short combinational step.
// Reset: i_rst_n low at a rising edge empties both registers and returns the
// parser to its start state, ready for the first key byte.
// Stall: while a result waits for i_ready, non-final beats keep flowing; only a
// second final beat waits in the input register until the result is taken.
module svcb_dnr_param_parser
    import dnr_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic        o_use_dot,
    output logic        o_use_http2,
    output logic        o_use_http3,
    output logic        o_use_quic,
    output logic [15:0] o_service_port,
    output logic        o_path_present,
    output logic [15:0] o_path_offset,
    output logic [15:0] o_path_length
);

`include "svcb_dnr_param_parser_assert.svh"

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       r_out_valid;
    t_result    r_out;
    t_result    core_result;
    logic       stage_adv;
    logic       step;

    // The core may take its beat unless it would produce a result with nowhere to go.
    assign stage_adv = !(r_in_valid && r_in_final && r_out_valid && !i_ready);
    assign step      = r_in_valid && stage_adv;
    assign o_ready   = !r_in_valid || stage_adv;

    dnr_parse_core #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_data_byte  (r_in_byte),
        .i_final_byte (r_in_final),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in_byte  <= i_data_byte;
            r_in_final <= i_final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (step && r_in_final) begin
            r_out <= core_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_use_dot      = r_out.use_dot;
    assign o_use_http2    = r_out.use_http2;
    assign o_use_http3    = r_out.use_http3;
    assign o_use_quic     = r_out.use_quic;
    assign o_service_port = r_out.service_port;
    assign o_path_present = r_out.path_present;
    assign o_path_offset  = r_out.path_offset;
    assign o_path_length  = r_out.path_length;

    `DNR_ASSERT(a_final_gives_result, i_clk, i_rst_n, r_in_valid && r_in_final && !r_out_valid |=> r_out_valid, "final beat did not produce a result")
    `DNR_ASSERT(a_status_code, i_clk, i_rst_n, r_out_valid |-> (o_status == ST_OK || o_status == ST_NOUSE || o_status == ST_BAD), "reserved status code")
    `DNR_ASSERT(a_fail_clears_fields, i_clk, i_rst_n, r_out_valid && o_status != ST_OK |-> !o_use_dot && !o_use_http2 && !o_use_http3 && !o_use_quic && !o_path_present && o_service_port == 16'd0, "failed result carries fields")
    `DNR_ASSERT(a_http_needs_path, i_clk, i_rst_n, r_out_valid && o_status == ST_OK && (o_use_http2 || o_use_http3) |-> o_path_present, "HTTP transport without dohpath")

endmodule

// ===== hdl/dnr_parse_core.sv =====
// Byte-at-a-time SvcParams parser state and its next-state logic.
// Depends on dnr_pkg; produces the result of a final beat combinationally.
module dnr_parse_core
    import dnr_pkg::*;
#(
    parameter int OFFSET_WIDTH = DEF_OFFSET_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_data_byte,
    input  logic       i_final_byte,
    output t_result    o_result
);

    localparam int PW = OFFSET_WIDTH + 1;

    typedef enum logic [2:0] {
        PH_KEY_HI = 3'd0,
        PH_KEY_LO = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_VALUE  = 3'd4
    } t_phase;

    t_phase                  r_phase, n_phase;
    logic [PW-1:0]           r_pos, n_pos;
    logic [15:0]             r_prev_key, n_prev_key;
    logic [15:0]             r_cur_key, n_cur_key;
    logic [15:0]             r_val_rem, n_val_rem;
    logic [15:0]             r_val_len, n_val_len;
    logic [7:0]              r_id_rem, n_id_rem;
    logic [7:0]              r_id_len, n_id_len;
    logic [23:0]             r_id_chars, n_id_chars;
    logic                    r_alpn_seen, n_alpn_seen;
    logic [3:0]              r_tflags, n_tflags;
    logic [15:0]             r_port, n_port;
    logic                    r_path_present, n_path_present;
    logic [OFFSET_WIDTH-1:0] r_path_off, n_path_off;
    logic [15:0]             r_path_len, n_path_len;
    logic [1:0]              r_outcome, n_outcome;
    logic [OFFSET_WIDTH-1:0] r_val_start, n_val_start;

    logic       end_val;
    logic       id_done;
    logic [7:0] id_idx;
    t_result    result;

    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_prev_key     = r_prev_key;
        n_cur_key      = r_cur_key;
        n_val_rem      = r_val_rem;
        n_val_len      = r_val_len;
        n_id_rem       = r_id_rem;
        n_id_len       = r_id_len;
        n_id_chars     = r_id_chars;
        n_alpn_seen    = r_alpn_seen;
        n_tflags       = r_tflags;
        n_port         = r_port;
        n_path_present = r_path_present;
        n_path_off     = r_path_off;
        n_path_len     = r_path_len;
        n_outcome      = r_outcome;
        n_val_start    = r_val_start;
        end_val        = 1'b0;
        id_done        = 1'b0;
        id_idx         = r_id_len - r_id_rem;
        result         = '0;

        // Bytes past the addressable range make the option malformed.
        if (r_pos[OFFSET_WIDTH] && n_outcome == ST_OK) begin
            n_outcome = ST_BAD;
        end

        if (n_outcome == ST_OK) begin
            unique case (r_phase)
                PH_KEY_HI: begin
                    n_cur_key = {i_data_byte, 8'd0};
                    n_phase   = PH_KEY_LO;
                end
                PH_KEY_LO: begin
                    n_cur_key = {r_cur_key[15:8], i_data_byte};
                    if (r_prev_key >= n_cur_key) begin
                        n_outcome = ST_BAD;
                    end
                    n_prev_key = n_cur_key;
                    n_phase    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_val_len = {i_data_byte, 8'd0};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_val_len   = {r_val_len[15:8], i_data_byte};
                    n_val_rem   = n_val_len;
                    n_val_start = r_pos[OFFSET_WIDTH-1:0] + OFFSET_WIDTH'(1);
                    n_id_rem    = '0;
                    n_id_len    = '0;
                    n_id_chars  = '0;
                    n_phase     = PH_VALUE;
                    case (n_cur_key) inside
                        KEY_MANDATORY: begin
                            if (n_val_len != 16'd0) begin
                                n_outcome = ST_BAD;
                            end
                        end
                        KEY_ALPN: begin
                            if (n_val_len == 16'd0) begin
                                n_outcome = ST_NOUSE;
                            end else begin
                                n_alpn_seen = 1'b1;
                            end
                        end
                        KEY_PORT: begin
                            if (n_val_len != 16'd2) begin
                                n_outcome = ST_BAD;
                            end
                            n_port = '0;
                        end
                        KEY_IPV4HINT, KEY_IPV6HINT: begin
                            n_outcome = ST_BAD;
                        end
                        default: ;
                    endcase
                    end_val = (n_val_len == 16'd0) && (n_outcome == ST_OK);
                end
                default: begin
                    if (r_cur_key == KEY_ALPN) begin
                        if (r_id_rem == 8'd0) begin
                            // A zero-length id matches nothing.
                            n_id_len   = i_data_byte;
                            n_id_rem   = i_data_byte;
                            n_id_chars = '0;
                        end else begin
                            if (id_idx == 8'd0) begin
                                n_id_chars[7:0] = i_data_byte;
                            end else if (id_idx == 8'd1) begin
                                n_id_chars[15:8] = i_data_byte;
                            end else if (id_idx == 8'd2) begin
                                n_id_chars[23:16] = i_data_byte;
                            end
                            n_id_rem = r_id_rem - 8'd1;
                            id_done  = (n_id_rem == 8'd0);
                        end
                    end else if (r_cur_key == KEY_PORT) begin
                        n_port = {r_port[7:0], i_data_byte};
                    end else if (r_cur_key == KEY_DOHPATH) begin
                        if (i_data_byte == 8'd0) begin
                            n_outcome = ST_BAD;
                        end
                    end
                    n_val_rem = r_val_rem - 16'd1;
                    end_val   = (n_val_rem == 16'd0);
                end
            endcase
        end

        if (id_done) begin
            if (n_id_len == 8'd3 && n_id_chars == ID_DOT) n_tflags[0] = 1'b1;
            if (n_id_len == 8'd2 && n_id_chars == ID_H2)  n_tflags[1] = 1'b1;
            if (n_id_len == 8'd2 && n_id_chars == ID_H3)  n_tflags[2] = 1'b1;
            if (n_id_len == 8'd3 && n_id_chars == ID_DOQ) n_tflags[3] = 1'b1;
        end

        if (end_val) begin
            if (n_cur_key == KEY_ALPN) begin
                if (n_id_rem != 8'd0 && n_outcome == ST_OK) begin
                    n_outcome = ST_BAD;
                end
            end else if (n_cur_key == KEY_PORT) begin
                if (n_port == 16'd0 && n_outcome == ST_OK) begin
                    n_outcome = ST_BAD;
                end
            end else if (n_cur_key == KEY_DOHPATH) begin
                n_path_present = 1'b1;
                n_path_off     = n_val_start;
                n_path_len     = n_val_len;
            end
            n_phase = PH_KEY_HI;
        end

        if (!r_pos[OFFSET_WIDTH]) begin
            n_pos = r_pos + PW'(1);
        end

        // Closing checks on the last beat of the option.
        if (i_final_byte && n_outcome == ST_OK) begin
            if (n_phase != PH_KEY_HI) begin
                n_outcome = ST_BAD;
            end else if (!n_alpn_seen) begin
                n_outcome = ST_BAD;
            end else if (!n_path_present && (n_tflags[1] || n_tflags[2])) begin
                n_outcome = ST_BAD;
            end else if (n_tflags == 4'd0) begin
                n_outcome = ST_NOUSE;
            end
        end
        result.status = n_outcome;
        if (n_outcome == ST_OK) begin
            result.use_dot      = n_tflags[0];
            result.use_http2    = n_tflags[1];
            result.use_http3    = n_tflags[2];
            result.use_quic     = n_tflags[3];
            result.service_port = n_port;
            result.path_present = n_path_present;
            result.path_offset  = n_path_present ? 16'(n_path_off) : 16'd0;
            result.path_length  = n_path_present ? n_path_len : 16'd0;
        end
    end

    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_final_byte)) begin
            r_phase        <= PH_KEY_HI;
            r_pos          <= '0;
            r_prev_key     <= '0;
            r_cur_key      <= '0;
            r_val_rem      <= '0;
            r_val_len      <= '0;
            r_id_rem       <= '0;
            r_id_len       <= '0;
            r_id_chars     <= '0;
            r_alpn_seen    <= 1'b0;
            r_tflags       <= '0;
            r_port         <= '0;
            r_path_present <= 1'b0;
            r_path_off     <= '0;
            r_path_len     <= '0;
            r_outcome      <= ST_OK;
            r_val_start    <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_pos          <= n_pos;
            r_prev_key     <= n_prev_key;
            r_cur_key      <= n_cur_key;
            r_val_rem      <= n_val_rem;
            r_val_len      <= n_val_len;
            r_id_rem       <= n_id_rem;
            r_id_len       <= n_id_len;
            r_id_chars     <= n_id_chars;
            r_alpn_seen    <= n_alpn_seen;
            r_tflags       <= n_tflags;
            r_port         <= n_port;
            r_path_present <= n_path_present;
            r_path_off     <= n_path_off;
            r_path_len     <= n_path_len;
            r_outcome      <= n_outcome;
            r_val_start    <= n_val_start;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for svcb_dnr_param_parser: feeds SvcParams options one beat per byte
// and checks every result beat against a byte-level parser kept alongside the block.
// Depends on dnr_pkg and the RTL of svcb_dnr_param_parser only.
module tb;
    import dnr_pkg::*;

    localparam int unsigned POS_MAX    = (1 << DEF_OFFSET_WIDTH) - 1;
    localparam int          RUN_LIMIT  = 1_000_000;
    localparam int          IDLE_MAX   = 18;
    localparam int          HOLD_LONG  = 400;

    typedef enum logic [2:0] {AT_KEY_HI, AT_KEY_LO, AT_LEN_HI, AT_LEN_LO, AT_VALUE} t_phase;

    // Byte-level parser of one option, plus the queue of results that it has produced.
    class svcparams_parser_model;
        t_phase      phase;
        int unsigned byte_pos;
        logic [15:0] prev_key, cur_key, val_left, val_len, val_start;
        logic [7:0]  id_left, id_len;
        logic [23:0] id_chars;
        bit          alpn_seen, has_dot, has_h2, has_h3, has_doq, path_seen;
        logic [15:0] svc_port, path_off, path_len;
        logic [1:0]  outcome;
        t_result     option_results[$];
        int          mismatches, results_seen, options_seen, bytes_seen;

        function void restart();
            phase = AT_KEY_HI;
            byte_pos = 0;
            prev_key = '0;
            cur_key = '0;
            val_left = '0;
            val_len = '0;
            val_start = '0;
            id_left = '0;
            id_len = '0;
            id_chars = '0;
            alpn_seen = 0;
            has_dot = 0;
            has_h2 = 0;
            has_h3 = 0;
            has_doq = 0;
            path_seen = 0;
            svc_port = '0;
            path_off = '0;
            path_len = '0;
            outcome = ST_OK;
        endfunction

        // ST_OK doubles as "nothing latched yet".
        function void set_outcome(logic [1:0] o);
            if (outcome == ST_OK) outcome = o;
        endfunction

        function void match_alpn_id();
            if (id_len == 3 && id_chars == ID_DOT) has_dot = 1;
            if (id_len == 2 && id_chars == ID_H2) has_h2 = 1;
            if (id_len == 2 && id_chars == ID_H3) has_h3 = 1;
            if (id_len == 3 && id_chars == ID_DOQ) has_doq = 1;
        endfunction

        function void close_value();
            if (cur_key == KEY_ALPN) begin
                if (id_left != 0) set_outcome(ST_BAD);
            end else if (cur_key == KEY_PORT) begin
                if (svc_port == 0) set_outcome(ST_BAD);
            end else if (cur_key == KEY_DOHPATH) begin
                path_seen = 1;
                path_off = val_start;
                path_len = val_len;
            end
            phase = AT_KEY_HI;
        endfunction

        function void start_value();
            val_left = val_len;
            val_start = 16'(byte_pos + 1);
            id_left = '0;
            id_len = '0;
            id_chars = '0;
            phase = AT_VALUE;
            case (cur_key)
                KEY_MANDATORY: if (val_len > 0) set_outcome(ST_BAD);
                KEY_ALPN: begin
                    if (val_len == 0) set_outcome(ST_NOUSE);
                    else alpn_seen = 1;
                end
                KEY_PORT: begin
                    if (val_len != 2) set_outcome(ST_BAD);
                    svc_port = '0;
                end
                KEY_IPV4HINT, KEY_IPV6HINT: set_outcome(ST_BAD);
                default: ;
            endcase
            if (val_len == 0 && outcome == ST_OK) close_value();
        endfunction

        function void value_byte(logic [7:0] b);
            int idx;
            if (cur_key == KEY_ALPN) begin
                if (id_left == 0) begin
                    id_len = b;
                    id_left = b;
                    id_chars = '0;
                    if (b == 0) match_alpn_id();
                end else begin
                    // Only the first three characters of an id are kept for matching.
                    idx = int'(id_len) - int'(id_left);
                    if (idx < 3) id_chars[8*idx +: 8] = b;
                    id_left--;
                    if (id_left == 0) match_alpn_id();
                end
            end else if (cur_key == KEY_PORT) begin
                svc_port = {svc_port[7:0], b};
            end else if (cur_key == KEY_DOHPATH && b == 8'h00) begin
                set_outcome(ST_BAD);
            end
            val_left--;
            if (val_left == 0) close_value();
        endfunction

        function void take_byte(logic [7:0] b, logic last_beat);
            t_result res;
            bytes_seen++;
            if (byte_pos > POS_MAX) set_outcome(ST_BAD);
            if (outcome == ST_OK) begin
                case (phase)
                    AT_KEY_HI: begin
                        cur_key = {b, 8'h00};
                        phase = AT_KEY_LO;
                    end
                    AT_KEY_LO: begin
                        cur_key[7:0] = b;
                        if (prev_key >= cur_key) set_outcome(ST_BAD);
                        prev_key = cur_key;
                        phase = AT_LEN_HI;
                    end
                    AT_LEN_HI: begin
                        val_len = {b, 8'h00};
                        phase = AT_LEN_LO;
                    end
                    AT_LEN_LO: begin
                        val_len[7:0] = b;
                        start_value();
                    end
                    default: value_byte(b);
                endcase
            end
            if (byte_pos <= POS_MAX) byte_pos++;
            if (last_beat) begin
                if (outcome == ST_OK) begin
                    if (phase != AT_KEY_HI || !alpn_seen) set_outcome(ST_BAD);
                    else if (!path_seen && (has_h2 || has_h3)) set_outcome(ST_BAD);
                    else if (!(has_dot || has_h2 || has_h3 || has_doq)) set_outcome(ST_NOUSE);
                end
                res = '0;
                res.status = outcome;
                if (outcome == ST_OK) begin
                    res.use_dot = has_dot;
                    res.use_http2 = has_h2;
                    res.use_http3 = has_h3;
                    res.use_quic = has_doq;
                    res.service_port = svc_port;
                    res.path_present = path_seen;
                    if (path_seen) begin
                        res.path_offset = path_off;
                        res.path_length = path_len;
                    end
                end
                option_results.push_back(res);
                options_seen++;
                restart();
            end
        endfunction

        function int outstanding();
            return option_results.size();
        endfunction

        function void compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on result %0d, %s: expected %0h, got %0h",
                             results_seen, what, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (option_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result beat with no option pending: status %0h", got.status);
                return;
            end
            want = option_results.pop_front();
            results_seen++;
            compare_field("status", 16'(want.status), 16'(got.status));
            compare_field("use_dot", 16'(want.use_dot), 16'(got.use_dot));
            compare_field("use_http2", 16'(want.use_http2), 16'(got.use_http2));
            compare_field("use_http3", 16'(want.use_http3), 16'(got.use_http3));
            compare_field("use_quic", 16'(want.use_quic), 16'(got.use_quic));
            compare_field("service_port", want.service_port, got.service_port);
            compare_field("path_present", 16'(want.path_present), 16'(got.path_present));
            compare_field("path_offset", want.path_offset, got.path_offset);
            compare_field("path_length", want.path_length, got.path_length);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_final_byte = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic        o_use_dot, o_use_http2, o_use_http3, o_use_quic;
    logic [15:0] o_service_port;
    logic        o_path_present;
    logic [15:0] o_path_offset, o_path_length;

    svcparams_parser_model parser_model = new;
    logic [7:0] opt_bytes[$];
    logic [7:0] val_bytes[$];
    int         tx_idle_max = IDLE_MAX;
    int         rx_idle_max = IDLE_MAX;
    int         rx_hold_cycles = 0;
    int         cycle_count = 0;

    svcb_dnr_param_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_data_byte    (i_data_byte),
        .i_final_byte   (i_final_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_use_dot      (o_use_dot),
        .o_use_http2    (o_use_http2),
        .o_use_http3    (o_use_http3),
        .o_use_quic     (o_use_quic),
        .o_service_port (o_service_port),
        .o_path_present (o_path_present),
        .o_path_offset  (o_path_offset),
        .o_path_length  (o_path_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= RUN_LIMIT) begin
                $display("Timed out after %0d cycles", cycle_count);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ---------------- option building ----------------

    function automatic void put16(int v);
        opt_bytes.push_back(v[15:8]);
        opt_bytes.push_back(v[7:0]);
    endfunction

    function automatic void put_param(int key);
        put16(key);
        put16(val_bytes.size());
        foreach (val_bytes[i]) opt_bytes.push_back(val_bytes[i]);
        val_bytes.delete();
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++) val_bytes.push_back(s[i]);
    endfunction

    function automatic void add_id(string s);
        val_bytes.push_back(8'(s.len()));
        add_text(s);
    endfunction

    function automatic void add_random(int n);
        repeat (n) val_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_dot_alpn();
        add_id("dot");
        put_param(KEY_ALPN);
    endfunction

    function automatic void build_random_option();
        int choice, n, k;
        if ($urandom_range(0, 99) < 6) begin
            repeat ($urandom_range(1, 24)) opt_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 49) == 0) begin
            add_random($urandom_range(0, 2));
            put_param(KEY_MANDATORY);
        end
        if ($urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 19) != 0) begin
                repeat ($urandom_range(1, 4)) begin
                    choice = $urandom_range(0, 6);
                    case (choice)
                        0: add_id("dot");
                        1: add_id("h2");
                        2: add_id("h3");
                        3: add_id("doq");
                        4: begin
                            if ($urandom_range(0, 1) == 1) add_id("dotx");
                            else add_id("h");
                        end
                        default: begin
                            n = $urandom_range(0, 4);
                            val_bytes.push_back(8'(n));
                            add_random(n);
                        end
                    endcase
                end
            end
            put_param(KEY_ALPN);
        end
        if ($urandom_range(0, 9) < 3) begin
            add_random($urandom_range(0, 6));
            put_param(2);
        end
        if ($urandom_range(0, 1) == 1) begin
            n = ($urandom_range(0, 9) == 0) ? 2 * $urandom_range(0, 1) + 1 : 2;
            if ($urandom_range(0, 9) == 0) repeat (n) val_bytes.push_back(8'h00);
            else add_random(n);
            put_param(KEY_PORT);
        end
        if ($urandom_range(0, 19) == 0) begin
            add_random(4);
            put_param(KEY_IPV4HINT);
        end
        if ($urandom_range(0, 4) == 0) begin
            add_random($urandom_range(0, 3));
            put_param(5);
        end
        if ($urandom_range(0, 19) == 0) begin
            add_random(16);
            put_param(KEY_IPV6HINT);
        end
        if ($urandom_range(0, 9) < 6) begin
            n = $urandom_range(0, 12);
            repeat (n) val_bytes.push_back(8'($urandom_range(8'h21, 8'h7E)));
            if (n > 0 && $urandom_range(0, 9) == 0) val_bytes[$urandom_range(0, n - 1)] = 8'h00;
            put_param(KEY_DOHPATH);
        end
        if ($urandom_range(0, 4) == 0) begin
            add_random($urandom_range(0, 4));
            put_param($urandom_range(8, 16'hFFFF));
        end
        // Occasionally break an otherwise well-formed option.
        choice = $urandom_range(0, 99);
        if (choice < 8 && opt_bytes.size() > 1) begin
            k = $urandom_range(1, opt_bytes.size() - 1);
            while (opt_bytes.size() > k) void'(opt_bytes.pop_back());
        end else if (choice < 14 && opt_bytes.size() > 0) begin
            opt_bytes[$urandom_range(0, opt_bytes.size() - 1)] = 8'($urandom);
        end else if (choice < 18) begin
            repeat ($urandom_range(1, 3)) opt_bytes.push_back(8'($urandom));
        end
        if (opt_bytes.size() == 0) opt_bytes.push_back(8'($urandom));
    endfunction

    // ---------------- driving ----------------

    // Called and returning at a falling edge.
    task automatic send_byte(input logic [7:0] value, input logic last_beat);
        int gap;
        gap = (tx_idle_max > 0) ? $urandom_range(0, tx_idle_max) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= value;
        i_final_byte <= last_beat;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        parser_model.take_byte(value, last_beat);
        @(negedge i_clk);
    endtask

    task automatic send_option();
        int n;
        n = opt_bytes.size();
        for (int i = 0; i < n; i++) send_byte(opt_bytes[i], i == n - 1);
        opt_bytes.delete();
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (parser_model.outstanding() != 0);
    endtask

    initial begin : result_sink
        int gap;
        t_result got;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = (rx_idle_max > 0) ? $urandom_range(0, rx_idle_max) : 0;
            if (rx_hold_cycles > 0) begin
                gap = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            got.status = o_status;
            got.use_dot = o_use_dot;
            got.use_http2 = o_use_http2;
            got.use_http3 = o_use_http3;
            got.use_quic = o_use_quic;
            got.service_port = o_service_port;
            got.path_present = o_path_present;
            got.path_offset = o_path_offset;
            got.path_length = o_path_length;
            parser_model.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int rand_opts, rand_bytes;
        parser_model.restart();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed options, one case each.
        put_dot_alpn();
        send_option();
        add_id("h2");
        add_id("h3");
        put_param(KEY_ALPN);
        put16(KEY_PORT); put16(2); put16(853);
        add_text("/dns-query{?dns}");
        put_param(KEY_DOHPATH);
        send_option();
        add_id("doq");
        put_param(KEY_ALPN);
        put16(KEY_PORT); put16(2); put16(16'hFFFF);
        put_param(KEY_DOHPATH);
        send_option();
        put_param(KEY_MANDATORY);
        put_dot_alpn();
        send_option();
        put_param(KEY_ALPN);
        send_option();
        add_id("h2");
        put_param(KEY_ALPN);
        send_option();
        put16(KEY_PORT); put16(2); put16(53);
        send_option();
        add_id("xyz");
        add_id("");
        add_id("dotx");
        put_param(KEY_ALPN);
        send_option();
        put_dot_alpn();
        add_text("a");
        val_bytes.push_back(8'h00);
        add_text("b");
        put_param(KEY_DOHPATH);
        send_option();
        put_dot_alpn();
        add_random(4);
        put_param(KEY_IPV4HINT);
        send_option();
        put_dot_alpn();
        add_random(16);
        put_param(KEY_IPV6HINT);
        send_option();
        put_dot_alpn();
        add_random(3);
        put_param(KEY_PORT);
        send_option();
        put_dot_alpn();
        put16(KEY_PORT); put16(2); put16(0);
        send_option();
        put_dot_alpn();
        put_dot_alpn();
        send_option();
        put_dot_alpn();
        val_bytes.push_back(8'h00);
        val_bytes.push_back(8'hFF);
        put_param(2);
        put_param(5);
        val_bytes.push_back(8'hFF);
        val_bytes.push_back(8'hFF);
        put_param(16'hFFFF);
        send_option();
        // An ALPN id that claims more bytes than the value holds.
        val_bytes.push_back(8'd5);
        add_text("dot");
        put_param(KEY_ALPN);
        send_option();
        put_dot_alpn();
        put16(KEY_DOHPATH); put16(4);
        opt_bytes.push_back(8'h2F);
        opt_bytes.push_back(8'h61);
        send_option();
        put_dot_alpn();
        opt_bytes.push_back(8'h00);
        send_option();
        opt_bytes.push_back(8'hFF);
        send_option();
        drain();

        // Random options, with stretches where one or both sides run without gaps.
        rand_opts = 0;
        rand_bytes = 0;
        while (rand_bytes < 450 || rand_opts < 24) begin
            if (rand_opts == 20) begin
                // Hold the result side back while short options are offered back to back.
                drain();
                rx_hold_cycles = HOLD_LONG;
                tx_idle_max = 0;
                repeat (6) begin
                    put_dot_alpn();
                    put16(KEY_PORT); put16(2); put16($urandom_range(1, 16'hFFFF));
                    send_option();
                end
                drain();
            end
            tx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            rx_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
            build_random_option();
            rand_bytes += opt_bytes.size();
            send_option();
            rand_opts++;
        end
        drain();
        repeat (12) @(negedge i_clk);

        $display("Covered %0d options in %0d bytes: directed cases for each rule,",
                 parser_model.options_seen, parser_model.bytes_seen);
        $display("%0d random options and a long result stall; %0d results checked, %0d mismatches.",
                 rand_opts, parser_model.results_seen, parser_model.mismatches);
        if (parser_model.mismatches == 0 && parser_model.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
